>>> hdl/vmalu_pkg.sv
// shared types and constants for the vm integer alu with register file
`default_nettype none

package vmalu_pkg;

    localparam int DATA_W        = 64;
    localparam int HALF_W        = DATA_W / 2;
    localparam int MODE_W        = 4;
    localparam int DEST_W        = 4;
    localparam int DEST_CODES    = 2 ** DEST_W;
    localparam int REG_COUNT_DEF = 16;
    localparam int DIV_STEPS     = DATA_W;
    localparam int CNT_W         = $clog2(DIV_STEPS);
    localparam int MUL_STEPS     = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 4'd0,
        MODE_SUB  = 4'd1,
        MODE_MUL  = 4'd2,
        MODE_DIV  = 4'd3,
        MODE_MOD  = 4'd4,
        MODE_ABS  = 4'd5,
        MODE_MIN  = 4'd6,
        MODE_MAX  = 4'd7,
        MODE_SHL  = 4'd8,
        MODE_SHR  = 4'd9,
        MODE_NEG  = 4'd10,
        MODE_LOAD = 4'd11
    } t_mode;

    typedef enum logic [0:0] {
        STAT_DONE    = 1'b0,
        STAT_DIVZERO = 1'b1
    } t_status;

    typedef struct packed {
        logic       load;
        logic       div_init;
        logic       div_step;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       commit;
    } t_cmd;

    typedef struct packed {
        logic is_mul;
        logic is_div;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/vm_integer_alu_regfile.sv
// top level: vm integer alu working on a file of signed 64-bit registers
// beat path: operands loaded, register read, then four passes through one 32x32 multiplier
// for mul or one quotient bit a cycle for div and mod; other modes and a zero divisor go
// straight to done, which commits a registered result once the output is free
// one item at a time: next input beat taken only back in idle, even while a result waits
// synchronous reset clears control state and marks every register as zero
`default_nettype none

module vm_integer_alu_regfile
    import vmalu_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [MODE_W-1:0]        i_mode,
    input  wire logic signed [DATA_W-1:0] i_operand_a,
    input  wire logic signed [DATA_W-1:0] i_operand_b,
    input  wire logic [DEST_W-1:0]        i_dest_reg,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic                          o_status,
    output logic signed [DATA_W-1:0]      o_written_value
);

    t_cmd w_cmd;
    t_sts w_sts;

    vmalu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    vmalu_dp #(
        .REG_COUNT (REG_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_mode          (i_mode),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .i_dest_reg      (i_dest_reg),
        .o_status        (o_status),
        .o_written_value (o_written_value)
    );

endmodule

`default_nettype wire

>>> hdl/vmalu_ram.sv
// generic single-write, registered-read ram
`default_nettype none

module vmalu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> hdl/vmalu_dp.sv
// datapath: operand registers, multiply and divide units, result select, register file
`default_nettype none

module vmalu_dp
    import vmalu_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_sts                          o_sts,
    input  wire logic [MODE_W-1:0]        i_mode,
    input  wire logic signed [DATA_W-1:0] i_operand_a,
    input  wire logic signed [DATA_W-1:0] i_operand_b,
    input  wire logic [DEST_W-1:0]        i_dest_reg,
    output logic                          o_status,
    output logic signed [DATA_W-1:0]      o_written_value
);

    localparam int IDX_W = $clog2(REG_COUNT);

    logic [MODE_W-1:0]        r_mode;
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_b;
    logic [IDX_W-1:0]         r_idx;
    logic [REG_COUNT-1:0]     r_vld;

    logic [DATA_W-1:0]        r_prod;
    logic [DATA_W-1:0]        r_acc;

    logic [DATA_W-1:0]        r_rem;
    logic [DATA_W-1:0]        r_quo;
    logic [DATA_W-1:0]        r_dvs;
    logic                     r_neg_q;
    logic                     r_neg_r;

    logic [IDX_W-1:0]         w_idx_tab [DEST_CODES];
    logic [DATA_W-1:0]        w_rd_data;
    logic [DATA_W-1:0]        w_cur;
    logic [HALF_W-1:0]        w_ma;
    logic [HALF_W-1:0]        w_mb;
    logic [DATA_W:0]          w_rem_sh;
    logic [DATA_W+1:0]        w_diff;
    logic [DATA_W-1:0]        w_res;
    logic                     w_wr;
    logic                     w_err;
    logic                     w_bzero;

    // register index wraps modulo the register count
    for (genvar k = 0; k < DEST_CODES; k++) begin : g_idx
        localparam int Wrap = k % REG_COUNT;
        assign w_idx_tab[k] = IDX_W'(Wrap);
    end

    assign w_bzero      = (r_b == '0);
    assign o_sts.is_mul = (r_mode == MODE_MUL);
    assign o_sts.is_div = ((r_mode == MODE_DIV) || (r_mode == MODE_MOD)) && !w_bzero;

    vmalu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_regs (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit && w_wr),
        .i_wr_addr (r_idx),
        .i_wr_data (w_res),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    assign w_cur = r_vld[r_idx] ? w_rd_data : '0;

    // operand halves for the shared 32x32 multiplier
    always_comb begin
        case (i_cmd.mul_step)
            2'd0: begin
                w_ma = r_a[HALF_W-1:0];
                w_mb = r_b[HALF_W-1:0];
            end
            2'd1: begin
                w_ma = r_a[DATA_W-1:HALF_W];
                w_mb = r_b[HALF_W-1:0];
            end
            default: begin
                w_ma = r_a[HALF_W-1:0];
                w_mb = r_b[DATA_W-1:HALF_W];
            end
        endcase
    end

    // one restoring division step
    assign w_rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_dvs};

    always_comb begin
        w_res = '0;
        w_wr  = 1'b1;
        w_err = 1'b0;
        case (r_mode)
            MODE_ADD:  w_res = r_a + r_b;
            MODE_SUB:  w_res = r_a - r_b;
            MODE_MUL:  w_res = r_acc;
            MODE_DIV: begin
                if (w_bzero) begin
                    w_wr  = 1'b0;
                    w_err = 1'b1;
                end else begin
                    w_res = r_neg_q ? (~r_quo + 1'b1) : r_quo;
                end
            end
            MODE_MOD: begin
                if (w_bzero) begin
                    w_wr  = 1'b0;
                    w_err = 1'b1;
                end else begin
                    w_res = r_neg_r ? (~r_rem + 1'b1) : r_rem;
                end
            end
            MODE_ABS:  w_res = r_a[DATA_W-1] ? (~r_a + 1'b1) : r_a;
            MODE_MIN:  w_res = (r_a < r_b) ? r_a : r_b;
            MODE_MAX:  w_res = (r_b < r_a) ? r_a : r_b;
            MODE_SHL:  w_res = {w_cur[DATA_W-2:0], 1'b0};
            MODE_SHR:  w_res = {w_cur[DATA_W-1], w_cur[DATA_W-1:1]};
            MODE_NEG:  w_res = ~w_cur + 1'b1;
            MODE_LOAD: w_res = r_a;
            default:   w_wr  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_a    <= i_operand_a;
            r_b    <= i_operand_b;
            r_idx  <= w_idx_tab[i_dest_reg];
        end

        if (i_cmd.mul_en) begin
            r_prod <= w_ma * w_mb;
            case (i_cmd.mul_step)
                2'd0:    r_acc <= r_acc;
                2'd1:    r_acc <= r_prod;
                default: r_acc <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
            endcase
        end

        if (i_cmd.div_init) begin
            r_rem   <= '0;
            r_quo   <= r_a[DATA_W-1] ? (~r_a + 1'b1) : r_a;
            r_dvs   <= r_b[DATA_W-1] ? (~r_b + 1'b1) : r_b;
            r_neg_q <= r_a[DATA_W-1] ^ r_b[DATA_W-1];
            r_neg_r <= r_a[DATA_W-1];
        end else if (i_cmd.div_step) begin
            if (!w_diff[DATA_W+1]) begin
                r_rem <= w_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end

        if (i_cmd.commit) begin
            o_status        <= w_err ? STAT_DIVZERO : STAT_DONE;
            o_written_value <= w_wr ? w_res : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.commit && w_wr) begin
            r_vld[r_idx] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> hdl/vmalu_ctrl.sv
// controller: sequences register read, multiply, divide and write-back per beat
`default_nettype none

module vmalu_ctrl
    import vmalu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    localparam logic [CNT_W-1:0] DivLast = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] MulLast = CNT_W'(MUL_STEPS - 1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_ovld;
    logic             n_ovld;
    logic             w_free;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovld;
    assign w_free  = !(r_ovld && i_stall);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                if (i_sts.is_mul) begin
                    n_state = S_MUL;
                end else if (i_sts.is_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = r_cnt[1:0];
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == MulLast) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DivLast) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovld = r_ovld && i_stall;
        if (o_cmd.commit) begin
            n_ovld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
    end

endmodule

`default_nettype wire
